// ===== rtl/core/swso_pkg.sv =====
// ----------------------------------------------------------------------------
// swso_pkg - shared definitions for the single-wire sensor overheat alarm
// Field widths, register map, reset values and key codes used by the
// channel interfaces and the core.
// ----------------------------------------------------------------------------
package swso_pkg;

	// Frame layout: bytes read per frame, of which the first four are published
	localparam int FRAME_BYTES   = 4;
	localparam int READING_BYTES = 4;
	localparam int READ_IDX_W    = $clog2(READING_BYTES);
	localparam int BYTE_IDX_W    = $clog2(FRAME_BYTES + 1);

	// Field and register widths
	localparam int BYTE_W     = 8;
	localparam int REQUEST_W  = 16;
	localparam int DELAY_W    = 8;
	localparam int THRESH_W   = 8;
	localparam int HOLD_W     = 24;
	localparam int TICK_W     = 24;
	localparam int BIT_IDX_W  = 3;
	localparam int PHASE_W    = 4;

	// Configuration port
	localparam int PADDR_W  = 4;
	localparam int PDATA_W  = 32;
	localparam int REG_IDX_W = 2;

	typedef logic [REG_IDX_W-1:0] reg_idx_t;

	localparam reg_idx_t REG_REQUEST_TICKS  = 2'd0;
	localparam reg_idx_t REG_SAMPLE_DELAY   = 2'd1;
	localparam reg_idx_t REG_OVERHEAT_THRES = 2'd2;
	localparam reg_idx_t REG_HOLD_TICKS     = 2'd3;

	// Register reset values
	localparam logic [REQUEST_W-1:0] REQUEST_TICKS_RST = 16'd18420;
	localparam logic [DELAY_W-1:0]   SAMPLE_DELAY_RST  = 8'd15;
	localparam logic [THRESH_W-1:0]  THRESHOLD_RST     = 8'd32;
	localparam logic [HOLD_W-1:0]    HOLD_TICKS_RST    = 24'd4600000;

	// Acknowledge keys that clear the buzzer
	localparam logic [BYTE_W-1:0] KEY_UPPER_S = 8'h53;
	localparam logic [BYTE_W-1:0] KEY_LOWER_S = 8'h73;

	typedef logic [BYTE_W-1:0] byte_t;

endpackage

// ===== rtl/core/swso_tick_if.sv =====
// ----------------------------------------------------------------------------
// swso_tick_if - input channel, one timer tick per transfer
// Carries the sampled data line and an optional received serial character.
// ----------------------------------------------------------------------------
interface swso_tick_if
	import swso_pkg::*;
	();

	logic        valid;
	logic        ready;
	logic        line_level;
	logic        key_valid;
	logic [BYTE_W-1:0] key_char;

	modport source (
		output valid,
		input  ready,
		output line_level,
		output key_valid,
		output key_char
	);

	modport sink (
		input  valid,
		output ready,
		input  line_level,
		input  key_valid,
		input  key_char
	);

endinterface

// ===== rtl/core/swso_status_if.sv =====
// ----------------------------------------------------------------------------
// swso_status_if - result channel, one status word per tick
// Carries line drive, alarm state and the last published reading.
// ----------------------------------------------------------------------------
interface swso_status_if
	import swso_pkg::*;
	();

	logic        valid;
	logic        ready;
	logic        drive_low;
	logic        buzzer_on;
	logic        reading_valid;
	logic [BYTE_W-1:0] humidity_int;
	logic [BYTE_W-1:0] humidity_frac;
	logic [BYTE_W-1:0] temp_int;
	logic [BYTE_W-1:0] temp_frac;
	logic        awaiting_key;

	modport source (
		output valid,
		input  ready,
		output drive_low,
		output buzzer_on,
		output reading_valid,
		output humidity_int,
		output humidity_frac,
		output temp_int,
		output temp_frac,
		output awaiting_key
	);

	modport sink (
		input  valid,
		output ready,
		input  drive_low,
		input  buzzer_on,
		input  reading_valid,
		input  humidity_int,
		input  humidity_frac,
		input  temp_int,
		input  temp_frac,
		input  awaiting_key
	);

endinterface

// ===== rtl/core/single_wire_sensor_overheat_alarm_core.sv =====
// ----------------------------------------------------------------------------
// single_wire_sensor_overheat_alarm_core - sensor reader with overheat alarm
// Requests a reading on a single-wire line, decodes the bit stream, publishes
// humidity and temperature and latches a buzzer when the temperature is high.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake              payload
//  tick      in    valid/ready            line_level, key_valid, key_char
//  status    out   valid/ready            drive_low, buzzer_on, reading_valid,
//                                         humidity_int/frac, temp_int/frac,
//                                         awaiting_key
//  apb       in    psel/penable, pready=1 4 registers at byte address 4*i
//
//  Each tick passes through the input register, then through the phase
//  logic into the result register. A new tick is taken every cycle
//  unless both stages are full and stalled; the result register frees
//  as it drains. A stalled status channel holds both stages; ready drops
//  only when both are full. Reset clears phase, counters, reading and
//  buzzer and restores register defaults; no clearing pass is needed.
//
module single_wire_sensor_overheat_alarm_core
	import swso_pkg::*;
	(
		input  logic               clk,
		input  logic               arst_n,
		swso_tick_if.sink          tick,
		swso_status_if.source      status,
		input  logic               psel,
		input  logic               penable,
		input  logic               pwrite,
		input  logic [PADDR_W-1:0] paddr,
		input  logic [PDATA_W-1:0] pwdata,
		output logic [PDATA_W-1:0] prdata,
		output logic               pready
	);

	// Phase codes
	localparam logic [PHASE_W-1:0] PH_REQUEST    = 4'd0;
	localparam logic [PHASE_W-1:0] PH_RESP_HIGH  = 4'd1;
	localparam logic [PHASE_W-1:0] PH_RESP_LOW   = 4'd2;
	localparam logic [PHASE_W-1:0] PH_RESP_HIGH2 = 4'd3;
	localparam logic [PHASE_W-1:0] PH_BIT_LOW    = 4'd4;
	localparam logic [PHASE_W-1:0] PH_BIT_DELAY  = 4'd5;
	localparam logic [PHASE_W-1:0] PH_BIT_HIGH   = 4'd6;
	localparam logic [PHASE_W-1:0] PH_HOLD       = 4'd7;
	localparam logic [PHASE_W-1:0] PH_WAIT_KEY   = 4'd8;

	// Configuration registers
	logic [REQUEST_W-1:0] request_ticks_q;
	logic [DELAY_W-1:0]   sample_delay_q;
	logic [THRESH_W-1:0]  threshold_q;
	logic [HOLD_W-1:0]    hold_ticks_q;

	// Input stage
	logic              valid_s1;
	logic              line_s1;
	logic              key_valid_s1;
	logic [BYTE_W-1:0] key_char_s1;

	// Sequencer state
	logic [PHASE_W-1:0]    phase_q,      phase_d;
	logic [TICK_W-1:0]     tick_count_q, tick_count_d;
	logic [TICK_W-1:0]     tick_inc;
	logic [BYTE_W-1:0]     shift_q,      shift_d;
	logic [BYTE_W-1:0]     shift_next;
	logic [BIT_IDX_W-1:0]  bit_idx_q,    bit_idx_d;
	logic [BYTE_IDX_W-1:0] byte_idx_q,   byte_idx_d;
	byte_t                 incoming_q [READING_BYTES];
	byte_t                 incoming_d [READING_BYTES];
	byte_t                 reading_q  [READING_BYTES];
	byte_t                 reading_d  [READING_BYTES];
	logic                  buzzer_q,     buzzer_d;
	logic                  drive;
	logic                  published;

	// Result register
	logic out_valid_q;
	logic advance;

	logic cfg_write;

	// ------------------------------------------------------------------
	// Configuration port
	// ------------------------------------------------------------------
	assign pready    = 1'b1;
	assign cfg_write = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			request_ticks_q <= REQUEST_TICKS_RST;
			sample_delay_q  <= SAMPLE_DELAY_RST;
			threshold_q     <= THRESHOLD_RST;
			hold_ticks_q    <= HOLD_TICKS_RST;
		end else if (cfg_write) begin
			unique case (paddr[PADDR_W-1:2])
				REG_REQUEST_TICKS:  request_ticks_q <= pwdata[REQUEST_W-1:0];
				REG_SAMPLE_DELAY:   sample_delay_q  <= pwdata[DELAY_W-1:0];
				REG_OVERHEAT_THRES: threshold_q     <= pwdata[THRESH_W-1:0];
				REG_HOLD_TICKS:     hold_ticks_q    <= pwdata[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	// Return the addressed register, zero-extended
	always_comb begin
		unique case (paddr[PADDR_W-1:2])
			REG_REQUEST_TICKS:  prdata = PDATA_W'(request_ticks_q);
			REG_SAMPLE_DELAY:   prdata = PDATA_W'(sample_delay_q);
			REG_OVERHEAT_THRES: prdata = PDATA_W'(threshold_q);
			REG_HOLD_TICKS:     prdata = PDATA_W'(hold_ticks_q);
			default:            prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Flow control: advance the input stage into the result register
	// ------------------------------------------------------------------
	assign advance    = valid_s1 & (~out_valid_q | status.ready);
	assign tick.ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	// Capture the tick payload on transfer
	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			line_s1      <= tick.line_level;
			key_valid_s1 <= tick.key_valid;
			key_char_s1  <= tick.key_char;
		end
	end

	// ------------------------------------------------------------------
	// Phase logic for the tick in the input stage
	// ------------------------------------------------------------------
	assign tick_inc   = tick_count_q + TICK_W'(1);
	assign shift_next = {shift_q[BYTE_W-2:0], line_s1};

	always_comb begin
		phase_d      = phase_q;
		tick_count_d = tick_count_q;
		shift_d      = shift_q;
		bit_idx_d    = bit_idx_q;
		byte_idx_d   = byte_idx_q;
		incoming_d   = incoming_q;
		reading_d    = reading_q;
		buzzer_d     = buzzer_q;
		drive        = 1'b0;
		published    = 1'b0;

		unique case (phase_q)
			PH_REQUEST: begin
				if (tick_count_q < TICK_W'(request_ticks_q)) begin
					drive = 1'b1;
					if (tick_inc >= TICK_W'(request_ticks_q)) begin
						phase_d      = PH_RESP_HIGH;
						tick_count_d = '0;
					end else begin
						tick_count_d = tick_inc;
					end
				end else begin
					phase_d      = PH_RESP_HIGH;
					tick_count_d = '0;
				end
			end
			PH_RESP_HIGH: begin
				if (!line_s1) phase_d = PH_RESP_LOW;
			end
			PH_RESP_LOW: begin
				if (line_s1) phase_d = PH_RESP_HIGH2;
			end
			PH_RESP_HIGH2: begin
				if (!line_s1) begin
					phase_d    = PH_BIT_LOW;
					bit_idx_d  = '0;
					byte_idx_d = '0;
					shift_d    = '0;
				end
			end
			PH_BIT_LOW: begin
				if (line_s1) begin
					phase_d      = PH_BIT_DELAY;
					tick_count_d = '0;
				end
			end
			PH_BIT_DELAY: begin
				if (tick_count_q < TICK_W'(sample_delay_q)) begin
					tick_count_d = tick_inc;
				end else begin
					// Sample the bit; close the byte on the eighth
					tick_count_d = '0;
					phase_d      = PH_BIT_HIGH;
					bit_idx_d    = bit_idx_q + BIT_IDX_W'(1);
					if (bit_idx_q == '1) begin
						shift_d = '0;
						if (byte_idx_q < BYTE_IDX_W'(READING_BYTES)) begin
							incoming_d[byte_idx_q[READ_IDX_W-1:0]] = shift_next;
						end
						if (byte_idx_q < BYTE_IDX_W'(FRAME_BYTES)) begin
							byte_idx_d = byte_idx_q + BYTE_IDX_W'(1);
						end
					end else begin
						shift_d = shift_next;
					end
				end
			end
			PH_BIT_HIGH: begin
				if (!line_s1) begin
					if (byte_idx_q >= BYTE_IDX_W'(FRAME_BYTES)) begin
						reading_d    = incoming_q;
						published    = 1'b1;
						phase_d      = PH_HOLD;
						tick_count_d = '0;
					end else begin
						phase_d = PH_BIT_LOW;
					end
				end
			end
			PH_HOLD: begin
				if (tick_count_q < TICK_W'(hold_ticks_q)) begin
					tick_count_d = tick_inc;
				end else begin
					tick_count_d = '0;
					if (reading_q[2] >= threshold_q) begin
						buzzer_d = 1'b1;
						phase_d  = PH_WAIT_KEY;
					end else begin
						phase_d = PH_REQUEST;
					end
				end
			end
			PH_WAIT_KEY: begin
				if (key_valid_s1) begin
					if (key_char_s1 == KEY_LOWER_S || key_char_s1 == KEY_UPPER_S) begin
						buzzer_d = 1'b0;
					end
					phase_d      = PH_REQUEST;
					tick_count_d = '0;
				end
			end
			default: begin
				phase_d      = PH_REQUEST;
				tick_count_d = '0;
			end
		endcase
	end

	// Commit sequencer state once per processed tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_REQUEST;
			tick_count_q <= '0;
			shift_q      <= '0;
			bit_idx_q    <= '0;
			byte_idx_q   <= '0;
			buzzer_q     <= 1'b0;
			for (int i = 0; i < READING_BYTES; i++) begin
				incoming_q[i] <= '0;
				reading_q[i]  <= '0;
			end
		end else if (advance) begin
			phase_q      <= phase_d;
			tick_count_q <= tick_count_d;
			shift_q      <= shift_d;
			bit_idx_q    <= bit_idx_d;
			byte_idx_q   <= byte_idx_d;
			buzzer_q     <= buzzer_d;
			incoming_q   <= incoming_d;
			reading_q    <= reading_d;
		end
	end

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (status.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status.drive_low     <= drive;
			status.buzzer_on     <= buzzer_d;
			status.reading_valid <= published;
			status.humidity_int  <= reading_d[0];
			status.humidity_frac <= reading_d[1];
			status.temp_int      <= reading_d[2];
			status.temp_frac     <= reading_d[3];
			status.awaiting_key  <= (phase_d == PH_WAIT_KEY);
		end
	end

	assign status.valid = out_valid_q;

endmodule
